@@ rtl/srm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srm_pkg
// Widths, reset values, register indexes and codes shared by the
// supply rail monitor.
// ----------------------------------------------------------------------------
package srm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int VOLT_W     = 31;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 32;
    localparam int AVG_SHIFT  = 4;
    localparam int AVERAGE_FACTOR = 1 << AVG_SHIFT;
    localparam int AVG_W      = ACC_W + 1 - AVG_SHIFT;
    localparam int A_W        = 21;
    localparam int B_W        = 21;
    localparam int PROD_W     = B_W + VOLT_W;
    localparam int NUM_W      = VOLT_W + FRAC_W + 1;
    localparam int QUO_W      = VOLT_W;
    localparam int CNT_W      = $clog2(QUO_W);

    localparam int RAIL_W     = 2;
    localparam int RAIL_COUNT = 4;
    localparam int CFG_ADDR_W = 3;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 136;
    localparam int M_TUSER_W  = 2;

    localparam logic [VOLT_W-1:0] VOLT_MAX = {VOLT_W{1'b1}};
    localparam logic [3:0] BRIDGE_RATIO = 4'd11;

    localparam logic [VOLT_W-1:0] ZERO_OFFSET_RST    = 31'd17367040;
    localparam logic [VOLT_W-1:0] IO_SUPPLY_MIN_RST  = 31'd190054;
    localparam logic [VOLT_W-1:0] TARGET_MIN_RST     = 31'd111411;
    localparam logic [VOLT_W-1:0] TARGET_MAX_RST     = 31'd367002;
    localparam logic [VOLT_W-1:0] CORE_REFERENCE_RST = 31'd78643;
    localparam logic [VOLT_W-1:0] GAIN_RST           = 31'd65421;

    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_OFFSET    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IO_SUPPLY_MIN  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_MIN     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_MAX     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CORE_REFERENCE = 3'd4;

    localparam logic [RAIL_W-1:0] RAIL_IO     = 2'd0;
    localparam logic [RAIL_W-1:0] RAIL_CORE   = 2'd1;
    localparam logic [RAIL_W-1:0] RAIL_TARGET = 2'd2;
    localparam logic [RAIL_W-1:0] RAIL_BUS    = 2'd3;

    localparam logic [1:0] TC_LOW    = 2'd0;
    localparam logic [1:0] TC_WINDOW = 2'd1;
    localparam logic [1:0] TC_HIGH   = 2'd2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LED    = 1'b1;

    typedef logic [VOLT_W-1:0] volt_t;
    typedef logic [AVG_W-1:0]  avg_t;

    // Rounded average of the leaky accumulator
    function automatic avg_t acc_average(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + (ACC_W+1)'(AVERAGE_FACTOR / 2);
        return s[ACC_W:AVG_SHIFT];
    endfunction

endpackage

`default_nettype wire

@@ rtl/supply_rail_monitor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// supply_rail_monitor
// Core samples also pass through the gain divider, which takes 31 one-bit
// steps; a zero average or a saturating quotient skips the divider.
// Throughput: one item at a time; s_tready is high only while idle, and a
// result held by m_tready low keeps the block from finishing the next item.
// Reset: synchronous active-low aresetn restores control and config registers and state.
// Converts round-robin ADC samples to corrected rail volts, tracks the core
// average and gain, classifies rails and drives the status LED.
// ----------------------------------------------------------------------------
module supply_rail_monitor (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // [15:0] adc_sample, [16] led_request
    input  wire  [srm_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] req_type
    input  wire                             s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // [30:0] rail_volts, [32:31] next_rail, [33] io_supply_ok,
    // [35:34] target_class, [66:36] bus_volts, [97:67] core_average,
    // [128:98] gain_now, [130:129] power_bad_flags, [131] led_on
    output logic [srm_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] rail_index
    output logic [srm_pkg::M_TUSER_W-1:0]   m_tuser,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [srm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [srm_pkg::VOLT_W-1:0]      cfg_data
);
    import srm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CONV  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_AVG   = 4'd4;
    localparam logic [3:0] S_DIVI  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FLAGS = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // control registers
    logic [3:0]        state_reg, state_next;
    logic [RAIL_W-1:0] rail_ptr_reg, rail_ptr_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    avg_t              avg_reg, avg_next;
    volt_t             gain_reg, gain_next;
    volt_t             bus_reg, bus_next;
    logic              io_ok_reg, io_ok_next;
    logic [1:0]        tclass_reg, tclass_next;
    logic [1:0]        bad_reg, bad_next;
    logic [1:0]        prev_bad_reg, prev_bad_next;
    logic [1:0]        bad_cnt_reg, bad_cnt_next;
    logic              saved_led_reg, saved_led_next;
    logic              led_reg, led_next;
    logic              m_valid_reg, m_valid_next;
    volt_t             zero_offset_reg, io_min_reg, tgt_min_reg, tgt_max_reg, core_ref_reg;

    // payload registers
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [RAIL_W-1:0]    rail_reg, rail_next;
    logic [B_W-1:0]       b_reg, b_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    volt_t                volts_reg, volts_next;
    avg_t                 rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [M_TUSER_W-1:0] out_user_reg, out_user_next;

    // datapath
    logic [ACC_W-1:0]   raw_c, x_c;
    logic [ACC_W:0]     x_rnd_c;
    logic [A_W-1:0]     a_c;
    logic [A_W:0]       a_half_c, a_eighth_c;
    logic [A_W-3:0]     e_c;
    logic [A_W+2:0]     e11_c;
    logic [PROD_W:0]    prod_rnd_c;
    logic [PROD_W-FRAC_W:0] prod_sh_c;
    volt_t              volts_c;
    logic [ACC_W+AVG_SHIFT-1:0] acc_load_c;
    logic [ACC_W:0]     acc_sum_c;
    avg_t               acc_avg_c;
    logic [NUM_W-1:0]   num_c;
    logic [NUM_W-QUO_W-1:0] num_hi_c;
    logic [AVG_W:0]     trial_c, diff_c;
    logic               ge_c;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    assign acc_avg_c = acc_average(acc_reg);

    always_comb begin
        raw_c      = {sample_reg, {(ACC_W-SAMPLE_W){1'b0}}};
        x_c        = (raw_c > {1'b0, zero_offset_reg}) ? raw_c - {1'b0, zero_offset_reg}
                                                       : '0;
        x_rnd_c    = {1'b0, x_c} + (ACC_W+1)'(2048);
        a_c        = x_rnd_c[ACC_W:12];
        a_half_c   = {1'b0, a_c} + (A_W+1)'(1);
        a_eighth_c = {1'b0, a_c} + (A_W+1)'(4);
        e_c        = a_eighth_c[A_W:3];
        e11_c      = (A_W+3)'(e_c) * (A_W+3)'(BRIDGE_RATIO);

        prod_rnd_c = {1'b0, prod_reg} + (PROD_W+1)'(32768);
        prod_sh_c  = prod_rnd_c[PROD_W:FRAC_W];
        volts_c    = (prod_sh_c[PROD_W-FRAC_W:VOLT_W] != '0) ? VOLT_MAX
                                                              : prod_sh_c[VOLT_W-1:0];

        acc_load_c = (ACC_W+AVG_SHIFT)'(volts_reg) << AVG_SHIFT;
        acc_sum_c  = {1'b0, acc_reg} - (ACC_W+1)'(avg_reg) + (ACC_W+1)'(volts_reg);

        // divider operands from the freshly updated average
        num_c      = {1'b0, core_ref_reg, {FRAC_W{1'b0}}} + NUM_W'(acc_avg_c >> 1);
        num_hi_c   = num_c[NUM_W-1:QUO_W];

        trial_c    = {rem_reg, quo_reg[QUO_W-1]};
        diff_c     = trial_c - {1'b0, avg_reg};
        ge_c       = (trial_c >= {1'b0, avg_reg});
    end

    always_comb begin
        state_next     = state_reg;
        rail_ptr_next  = rail_ptr_reg;
        acc_next       = acc_reg;
        avg_next       = avg_reg;
        gain_next      = gain_reg;
        bus_next       = bus_reg;
        io_ok_next     = io_ok_reg;
        tclass_next    = tclass_reg;
        bad_next       = bad_reg;
        prev_bad_next  = prev_bad_reg;
        bad_cnt_next   = bad_cnt_reg;
        saved_led_next = saved_led_reg;
        led_next       = led_reg;
        m_valid_next   = m_valid_reg;
        sample_next    = sample_reg;
        rail_next      = rail_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        volts_next     = volts_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_LED) begin
                        saved_led_next = s_tdata[SAMPLE_W];
                        if (bad_reg == 2'b00) begin
                            led_next = s_tdata[SAMPLE_W];
                        end
                        rail_next  = RAIL_IO;
                        volts_next = '0;
                        state_next = S_OUT;
                    end else begin
                        sample_next = s_tdata[SAMPLE_W-1:0];
                        rail_next   = rail_ptr_reg;
                        state_next  = S_CONV;
                    end
                end
            end
            S_CONV: begin
                if (rail_reg == RAIL_IO || rail_reg == RAIL_CORE) begin
                    b_next = a_half_c[A_W:1];
                end else begin
                    b_next = e11_c[B_W-1:0];
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = PROD_W'(b_reg) * PROD_W'(gain_reg);
                state_next = S_SCALE;
            end
            S_SCALE: begin
                volts_next = volts_c;
                state_next = S_FLAGS;
                case (rail_reg)
                    RAIL_IO: begin
                        io_ok_next  = (volts_c >= io_min_reg);
                        bad_next[0] = !(volts_c >= io_min_reg);
                    end
                    RAIL_CORE: begin
                        state_next = S_AVG;
                    end
                    RAIL_TARGET: begin
                        if (volts_c < tgt_min_reg) begin
                            tclass_next = TC_LOW;
                        end else if (volts_c > tgt_max_reg) begin
                            tclass_next = TC_HIGH;
                        end else begin
                            tclass_next = TC_WINDOW;
                        end
                        bad_next[1] = !(volts_c < tgt_min_reg) && (volts_c > tgt_max_reg);
                    end
                    default: begin
                        bus_next = volts_c;
                    end
                endcase
            end
            S_AVG: begin
                if (acc_reg == '0) begin
                    acc_next = (acc_load_c[ACC_W+AVG_SHIFT-1:ACC_W] != '0) ? {ACC_W{1'b1}}
                                                                         : acc_load_c[ACC_W-1:0];
                end else begin
                    acc_next = acc_sum_c[ACC_W] ? {ACC_W{1'b1}} : acc_sum_c[ACC_W-1:0];
                end
                state_next = S_DIVI;
            end
            S_DIVI: begin
                avg_next   = acc_avg_c;
                state_next = S_DIV;
                if (acc_avg_c == '0) begin
                    state_next = S_FLAGS;
                end
            end
            S_DIV: begin
                // one quotient bit per cycle, operands loaded in S_DIVI
                if (div_cnt_reg == '0 && rem_reg == '1 && quo_reg == '1) begin
                    state_next = S_DIV;
                end
                if (rem_reg == avg_reg && div_cnt_reg == CNT_W'(QUO_W)) begin
                    state_next = S_FLAGS;
                end else if (div_cnt_reg == CNT_W'(QUO_W)) begin
                    state_next = S_FLAGS;
                end else begin
                    rem_next     = ge_c ? diff_c[AVG_W-1:0] : trial_c[AVG_W-1:0];
                    quo_next     = {quo_reg[QUO_W-2:0], ge_c};
                    div_cnt_next = div_cnt_reg + CNT_W'(1);
                    if (div_cnt_reg == CNT_W'(QUO_W - 1)) begin
                        gain_next  = {quo_reg[QUO_W-2:0], ge_c};
                        state_next = S_FLAGS;
                    end
                end
            end
            S_FLAGS: begin
                if (rail_reg == RAIL_BUS) begin
                    rail_ptr_next = RAIL_IO;
                end else begin
                    rail_ptr_next = rail_reg + RAIL_W'(1);
                end
                if (prev_bad_reg != bad_reg) begin
                    if (bad_reg == 2'b00) begin
                        bad_cnt_next = 2'd0;
                        led_next     = saved_led_reg;
                    end else if (prev_bad_reg == 2'b00) begin
                        led_next = 1'b1;
                    end
                    prev_bad_next = bad_reg;
                end
                if (bad_reg != 2'b00) begin
                    if (bad_cnt_next != 2'd3) begin
                        bad_cnt_next = bad_cnt_next + 2'd1;
                    end
                    if (bad_cnt_next == 2'd2) begin
                        led_next = !led_next;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    out_user_next = rail_reg;
                    out_data_next = {4'b0000, led_reg, bad_reg, gain_reg,
                                     {{(VOLT_W-AVG_W){1'b0}}, avg_reg}, bus_reg,
                                     tclass_reg, io_ok_reg, rail_ptr_reg, volts_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // divider load: quotient overflow saturates the gain at once
        if (state_reg == S_DIVI && acc_avg_c != '0) begin
            if ({{(AVG_W-(NUM_W-QUO_W)){1'b0}}, num_hi_c} >= acc_avg_c) begin
                gain_next  = VOLT_MAX;
                state_next = S_FLAGS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            rail_ptr_reg    <= RAIL_IO;
            acc_reg         <= '0;
            avg_reg         <= '0;
            gain_reg        <= GAIN_RST;
            bus_reg         <= '0;
            io_ok_reg       <= 1'b0;
            tclass_reg      <= TC_LOW;
            bad_reg         <= 2'b00;
            prev_bad_reg    <= 2'b00;
            bad_cnt_reg     <= 2'd0;
            saved_led_reg   <= 1'b1;
            led_reg         <= 1'b1;
            m_valid_reg     <= 1'b0;
            zero_offset_reg <= ZERO_OFFSET_RST;
            io_min_reg      <= IO_SUPPLY_MIN_RST;
            tgt_min_reg     <= TARGET_MIN_RST;
            tgt_max_reg     <= TARGET_MAX_RST;
            core_ref_reg    <= CORE_REFERENCE_RST;
        end else begin
            state_reg     <= state_next;
            rail_ptr_reg  <= rail_ptr_next;
            acc_reg       <= acc_next;
            avg_reg       <= avg_next;
            gain_reg      <= gain_next;
            bus_reg       <= bus_next;
            io_ok_reg     <= io_ok_next;
            tclass_reg    <= tclass_next;
            bad_reg       <= bad_next;
            prev_bad_reg  <= prev_bad_next;
            bad_cnt_reg   <= bad_cnt_next;
            saved_led_reg <= saved_led_next;
            led_reg       <= led_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_addr)
                    REG_ZERO_OFFSET:    zero_offset_reg <= cfg_data;
                    REG_IO_SUPPLY_MIN:  io_min_reg      <= cfg_data;
                    REG_TARGET_MIN:     tgt_min_reg     <= cfg_data;
                    REG_TARGET_MAX:     tgt_max_reg     <= cfg_data;
                    REG_CORE_REFERENCE: core_ref_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        rail_reg     <= rail_next;
        b_reg        <= b_next;
        prod_reg     <= prod_next;
        volts_reg    <= volts_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        if (state_reg == S_DIVI) begin
            rem_reg     <= AVG_W'(num_hi_c);
            quo_reg     <= num_c[QUO_W-1:0];
            div_cnt_reg <= '0;
        end else begin
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_prev_flags_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (prev_bad_reg == bad_reg))
        else $error("previous flags not settled while idle");

    a_count_clear_when_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && bad_reg == 2'b00) |-> (bad_cnt_reg == 2'd0))
        else $error("bad counter nonzero with power good");

    a_avg_tracks_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (avg_reg == acc_avg_c))
        else $error("average out of step with accumulator");

    a_led_req_keeps_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == REQ_LED) |=> (rail_ptr_reg == $past(rail_ptr_reg)))
        else $error("LED request moved the rail pointer");
`endif

endmodule

`default_nettype wire
